FILE: rtl/rgpg_pkg.sv
// Shared types, constants and constant functions of the radial glow pixel generator.
package rgpg_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int FRAC_BITS = 16;
   localparam int DIM_W     = 13;
   localparam int COORD_W   = 12;
   localparam int VALUE_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_DISC_SIZE     = 3'd2,
      CSR_EXPOSURE      = 3'd3,
      CSR_OUTPUT_FORMAT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
      logic [15:0]        disc_size;
      logic [15:0]        exposure;
      logic               output_format;
   } cfg_type;

   // integer square root, elaboration use only
   function automatic logic [63:0] isqrt64(logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v   = v_in;
      res = '0;
      for (int j = 31; j >= 0; j--) begin
         bitv = 64'(1) << (2 * j);
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
      end
      return res;
   endfunction

   // r_n ~ 2^(-2^-n) in Q0.30
   function automatic logic [29:0] exp_root(int n);
      logic [63:0] r;
      r = 64'(1) << 29;
      for (int j = 0; j < 16; j++) begin
         if (j < n) r = isqrt64(r << 30);
      end
      return r[29:0];
   endfunction

endpackage

FILE: rtl/rgpg_req_if.sv
// Request channel: one pixel coordinate per beat.
interface rgpg_req_if import rgpg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;

   modport source(output valid, pixel_x, pixel_y, input ready);
   modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

FILE: rtl/rgpg_rsp_if.sv
// Response channel: one glow value per beat.
interface rgpg_rsp_if import rgpg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] intensity;
   logic               coord_error;

   modport source(output valid, intensity, coord_error, input ready);
   modport sink(input valid, intensity, coord_error, output ready);
endinterface

FILE: rtl/rgpg_dist.sv
// Coordinate to rounded distance from image center: dividers, squares, root.
module rgpg_dist import rgpg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] pixel_x,
   input  logic [COORD_W-1:0] pixel_y,
   input  cfg_type            cfg,
   output logic               out_valid,
   output logic               out_error,
   output logic [15:0]        out_dist
);

   localparam int DIV_STEPS     = FRAC_BITS + 1;
   localparam int DIV_PER_STAGE = 3;
   localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
   localparam int SQ_STEPS      = 16;
   localparam int SQ_PER_STAGE  = 2;
   localparam int SQ_STAGES     = SQ_STEPS / SQ_PER_STAGE;
   localparam logic [16:0] HALF = 17'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic [11:0] dv;
      logic [12:0] rem;
      logic [16:0] quo;
      logic [16:0] num;
   } axis_div_type;

   typedef struct packed {
      logic         error;
      axis_div_type ax;
      axis_div_type ay;
   } div_stage_type;

   typedef struct packed {
      logic        error;
      logic [31:0] v;
      logic [31:0] res;
   } sq_stage_type;

   // restoring division, quotient bits MSB first
   function automatic axis_div_type div_step(axis_div_type a, int first);
      logic [13:0]  t;
      axis_div_type r;
      int           g;
      r = a;
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
         g = first + j;
         if (g < DIV_STEPS) begin
            t = {r.rem, r.num[DIV_STEPS-1-g]};
            if (t >= {2'b00, r.dv}) begin
               r.rem = 13'(t - {2'b00, r.dv});
               r.quo = {r.quo[15:0], 1'b1};
            end else begin
               r.rem = t[12:0];
               r.quo = {r.quo[15:0], 1'b0};
            end
         end
      end
      return r;
   endfunction

   function automatic logic [15:0] mag(logic [16:0] q);
      return (q >= HALF) ? 16'(q - HALF) : 16'(HALF - q);
   endfunction

   // digit-by-digit square root, bit walks down from 2^30
   function automatic sq_stage_type sq_step(sq_stage_type a, int first);
      sq_stage_type r;
      logic [31:0]  bitv;
      logic [32:0]  sum;
      r = a;
      for (int j = 0; j < SQ_PER_STAGE; j++) begin
         bitv = 32'(1) << (2 * (SQ_STEPS - 1 - (first + j)));
         sum  = {1'b0, r.res} + {1'b0, bitv};
         if ({1'b0, r.v} >= sum) begin
            r.v   = r.v - sum[31:0];
            r.res = (r.res >> 1) + bitv;
         end else begin
            r.res = r.res >> 1;
         end
      end
      return r;
   endfunction

   logic [DIM_W-1:0] w_sat, h_sat, dvx, dvy;
   div_stage_type    div_in;
   div_stage_type    div_ff [DIV_STAGES+1];
   logic             div_v_ff [DIV_STAGES+1];

   logic             mag_v_ff, mag_err_ff;
   logic [15:0]      mx_ff, my_ff;
   logic             sqr_v_ff, sqr_err_ff;
   logic [31:0]      sqx_ff, sqy_ff;
   sq_stage_type     sq_ff [SQ_STAGES+1];
   logic             sq_v_ff [SQ_STAGES+1];
   logic             out_v_ff, out_err_ff;
   logic [15:0]      out_dist_ff;

   always_comb begin
      w_sat = (cfg.image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_width;
      h_sat = (cfg.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_height;
      dvx   = (w_sat < DIM_W'(2)) ? DIM_W'(1) : w_sat - DIM_W'(1);
      dvy   = (h_sat < DIM_W'(2)) ? DIM_W'(1) : h_sat - DIM_W'(1);
      div_in.error  = ({1'b0, pixel_x} >= w_sat) || ({1'b0, pixel_y} >= h_sat);
      // numerator c*2^16 + dv/2; top bits above the quotient range seed the remainder
      div_in.ax.dv  = dvx[11:0];
      div_in.ax.rem = {2'b00, pixel_x[11:1]};
      div_in.ax.quo = '0;
      div_in.ax.num = {pixel_x[0], 5'b00000, dvx[11:1]};
      div_in.ay.dv  = dvy[11:0];
      div_in.ay.rem = {2'b00, pixel_y[11:1]};
      div_in.ay.quo = '0;
      div_in.ay.num = {pixel_y[0], 5'b00000, dvy[11:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) div_v_ff[0] <= 1'b0;
      else if (en) div_v_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) div_ff[0] <= div_in;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) div_v_ff[s+1] <= 1'b0;
         else if (en) div_v_ff[s+1] <= div_v_ff[s];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[s+1].error <= div_ff[s].error;
            div_ff[s+1].ax    <= div_step(div_ff[s].ax, s * DIV_PER_STAGE);
            div_ff[s+1].ay    <= div_step(div_ff[s].ay, s * DIV_PER_STAGE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_v_ff <= 1'b0;
         sqr_v_ff <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else if (en) begin
         mag_v_ff <= div_v_ff[DIV_STAGES];
         sqr_v_ff <= mag_v_ff;
         sq_v_ff[0] <= sqr_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_err_ff    <= div_ff[DIV_STAGES].error;
         mx_ff         <= mag(div_ff[DIV_STAGES].ax.quo);
         my_ff         <= mag(div_ff[DIV_STAGES].ay.quo);
         sqr_err_ff    <= mag_err_ff;
         sqx_ff        <= 32'(mx_ff) * 32'(mx_ff);
         sqy_ff        <= 32'(my_ff) * 32'(my_ff);
         sq_ff[0].error <= sqr_err_ff;
         sq_ff[0].v     <= sqx_ff + sqy_ff;
         sq_ff[0].res   <= '0;
      end
   end

   for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sq
      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[s+1] <= 1'b0;
         else if (en) sq_v_ff[s+1] <= sq_v_ff[s];
      end
      always_ff @(posedge clock) begin
         if (en) sq_ff[s+1] <= sq_step(sq_ff[s], s * SQ_PER_STAGE);
      end
   end

   // round to nearest: leftover v is d2 - res^2
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= sq_v_ff[SQ_STAGES];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_err_ff  <= sq_ff[SQ_STAGES].error;
         out_dist_ff <= sq_ff[SQ_STAGES].res[15:0]
                        + 16'(sq_ff[SQ_STAGES].v > sq_ff[SQ_STAGES].res);
      end
   end

   assign out_valid = out_v_ff;
   assign out_error = out_err_ff;
   assign out_dist  = out_dist_ff;

endmodule

FILE: rtl/rgpg_exp.sv
// Distance to glow value: disc clamp, exposure scale, base-2 exponential, output format.
module rgpg_exp import rgpg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic               in_error,
   input  logic [15:0]        in_dist,
   input  cfg_type            cfg,
   output logic               out_valid,
   output logic               out_error,
   output logic [VALUE_W-1:0] out_intensity
);

   localparam int ROOT_STAGES = 16;

   typedef struct packed {
      logic        error;
      logic [8:0]  k;
      logic [15:0] f;
      logic [30:0] p;
   } pow_stage_type;

   logic          t_v_ff, t_err_ff;
   logic [15:0]   t_ff;
   logic          e_v_ff, e_err_ff;
   logic [31:0]   e_ff;
   logic [54:0]   b_prod;
   pow_stage_type pw_ff [ROOT_STAGES+1];
   logic          pw_v_ff [ROOT_STAGES+1];
   logic          sh_v_ff, sh_err_ff;
   logic [30:0]   i30_ff;
   logic          out_v_ff, out_err_ff;
   logic [VALUE_W-1:0] out_val_ff;
   logic [38:0]   byte_sum;
   logic [31:0]   q15_sum;
   logic [VALUE_W-1:0] val_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_v_ff     <= 1'b0;
         e_v_ff     <= 1'b0;
         pw_v_ff[0] <= 1'b0;
      end else if (en) begin
         t_v_ff     <= in_valid;
         e_v_ff     <= t_v_ff;
         pw_v_ff[0] <= e_v_ff;
      end
   end

   assign b_prod = 55'(e_ff[31:FRAC_BITS-8]) * 55'(LOG2E_Q30);

   always_ff @(posedge clock) begin
      if (en) begin
         t_err_ff <= in_error;
         t_ff     <= (in_dist > cfg.disc_size) ? in_dist - cfg.disc_size : 16'd0;
         e_err_ff <= t_err_ff;
         e_ff     <= 32'(t_ff) * 32'(cfg.exposure);
         // b = a*log2(e) in Q.16: integer part k, fraction f
         pw_ff[0].error <= e_err_ff;
         pw_ff[0].k     <= b_prod[54:46];
         pw_ff[0].f     <= b_prod[45:30];
         pw_ff[0].p     <= 31'(1) << 30;
      end
   end

   for (genvar n = 1; n <= ROOT_STAGES; n++) begin : g_root
      localparam logic [29:0] ROOT = exp_root(n);
      logic [60:0] prod;
      assign prod = 61'(pw_ff[n-1].p) * 61'(ROOT) + (61'(1) << 29);
      always_ff @(posedge clock) begin
         if (reset) pw_v_ff[n] <= 1'b0;
         else if (en) pw_v_ff[n] <= pw_v_ff[n-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            pw_ff[n].error <= pw_ff[n-1].error;
            pw_ff[n].k     <= pw_ff[n-1].k;
            pw_ff[n].f     <= pw_ff[n-1].f;
            pw_ff[n].p     <= pw_ff[n-1].f[ROOT_STAGES-n] ? prod[60:30] : pw_ff[n-1].p;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         sh_v_ff  <= pw_v_ff[ROOT_STAGES];
         out_v_ff <= sh_v_ff;
      end
   end

   assign byte_sum = ({8'd0, i30_ff} << 8) - {8'd0, i30_ff} + (39'(1) << 29);
   assign q15_sum  = {1'b0, i30_ff} + (32'(1) << 14);

   always_comb begin
      if (sh_err_ff) val_in = '0;
      else if (cfg.output_format) val_in = q15_sum[30:15];
      else val_in = {7'd0, byte_sum[38:30]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sh_err_ff  <= pw_ff[ROOT_STAGES].error;
         // underflow when the integer part reaches 31
         i30_ff     <= (pw_ff[ROOT_STAGES].k >= 9'd31) ? 31'd0
                       : pw_ff[ROOT_STAGES].p >> pw_ff[ROOT_STAGES].k[4:0];
         out_err_ff <= sh_err_ff;
         out_val_ff <= val_in;
      end
   end

   assign out_valid     = out_v_ff;
   assign out_error     = out_err_ff;
   assign out_intensity = out_val_ff;

endmodule

FILE: rtl/radial_glow_pixel_generator.sv
// Throughput: one pixel per cycle while the response is not stalled; all 40 pipeline stages advance together.
// A stalled response holds the whole pipeline; nothing is dropped or repeated.
// Depth is set by the 17-bit offset dividers, the 16-step root and the 16 exp multipliers.
// Reset (synchronous, active high) clears all valid bits and restores the registers
// to width 256, height 256, disc 0, exposure 10.0 and byte output.
module radial_glow_pixel_generator import rgpg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   rgpg_req_if.sink             req_bus,
   rgpg_rsp_if.source           rsp_bus,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cfg_type      cfg_ff;
   logic         en;
   logic         d_valid, d_error;
   logic [15:0]  d_dist;
   logic         o_valid, o_error;
   logic [VALUE_W-1:0] o_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= DIM_W'(256);
         cfg_ff.image_height  <= DIM_W'(256);
         cfg_ff.disc_size     <= 16'd0;
         cfg_ff.exposure      <= 16'd2560;
         cfg_ff.output_format <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_ff.image_width   <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:  cfg_ff.image_height  <= csr_data[DIM_W-1:0];
            CSR_DISC_SIZE:     cfg_ff.disc_size     <= csr_data;
            CSR_EXPOSURE:      cfg_ff.exposure      <= csr_data;
            CSR_OUTPUT_FORMAT: cfg_ff.output_format <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline moves whenever the output slot is free or being drained
   assign en            = !o_valid || rsp_bus.ready;
   assign req_bus.ready = en;

   rgpg_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .pixel_x   (req_bus.pixel_x),
      .pixel_y   (req_bus.pixel_y),
      .cfg       (cfg_ff),
      .out_valid (d_valid),
      .out_error (d_error),
      .out_dist  (d_dist)
   );

   rgpg_exp u_exp (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (d_valid),
      .in_error      (d_error),
      .in_dist       (d_dist),
      .cfg           (cfg_ff),
      .out_valid     (o_valid),
      .out_error     (o_error),
      .out_intensity (o_value)
   );

   assign rsp_bus.valid       = o_valid;
   assign rsp_bus.intensity   = o_value;
   assign rsp_bus.coord_error = o_error;

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.coord_error) |-> (rsp_bus.intensity == '0))
      else $error("coordinate error beat with nonzero intensity");

   a_byte_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !cfg_ff.output_format) |-> (rsp_bus.intensity <= 16'd255))
      else $error("byte mode intensity above 255");

   a_q15_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && cfg_ff.output_format) |-> (rsp_bus.intensity <= 16'd32768))
      else $error("Q1.15 intensity above one");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request taken while the response beat is stalled");

endmodule
